>>> design/sqd_pkg.sv
// Shared constants, item types and the lane arithmetic of the squared L2
// distance block. No dependencies.
package sqd_pkg;

  localparam int unsigned Lanes     = 4;
  localparam int unsigned CodeW     = 8;
  localparam int unsigned CountW    = 3;
  localparam int unsigned SqW       = 2 * CodeW;
  localparam int unsigned LaneSumW  = SqW + $clog2(Lanes + 1);
  localparam int unsigned DistW     = 32;
  localparam int unsigned MidDepth  = 4;
  localparam int unsigned OutDepth  = 2;

  localparam logic [CodeW-1:0] QueryOffset = 8'h80;

  typedef struct packed {
    logic [LaneSumW-1:0] lane_sum;
    logic                last;
  } sqd_item_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             saturated;
  } sqd_result_t;

  function automatic logic [SqW-1:0] lane_square(input logic [CodeW-1:0] rec,
                                                 input logic [CodeW-1:0] qry);
    logic [CodeW-1:0] raw;
    logic [CodeW:0]   diff;
    logic [CodeW-1:0] mag;
    raw  = rec ^ QueryOffset;
    diff = {1'b0, raw} - {1'b0, qry};
    mag  = diff[CodeW] ? CodeW'(-diff) : diff[CodeW-1:0];
    return SqW'(mag) * SqW'(mag);
  endfunction

endpackage

>>> design/query_sq_l2_uint8_distance.sv
// Top level of the streaming squared L2 distance block between int8 record
// codes and uint8 query codes. Depends on sqd_pkg, sqd_front, sqd_back and
// sqd_fifo.
//
// The input side is a queue: an item is taken at a rising edge with push high
// and full low. Each item carries up to four element pairs; lanes_valid says
// how many low lanes hold real elements (values above four count as four).
// The item marked last_of_record closes the record and produces one result.
// The output side is a queue too: while empty is low the oldest result is on
// distance_o and saturated_o, and it leaves at an edge with pop high.
// An item flows through two front stages (lane squares, then lane sum), a
// four-entry queue and the accumulator, so a result is visible once its
// closing item has passed them and reached the result queue. One item is taken
// every cycle while full is low; the single accumulator add sets the rate.
// A stalled receiver fills the two-entry result queue, then the middle
// queue, and full rises once the front stages hold as well; items that do not
// close a record still drain into the accumulator meanwhile.
// Reset clears the pipeline, both queues and the accumulator; full is low and
// empty is high straight after it.
module query_sq_l2_uint8_distance (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic signed [sqd_pkg::CodeW-1:0]  record_lane0_i,
  input  logic signed [sqd_pkg::CodeW-1:0]  record_lane1_i,
  input  logic signed [sqd_pkg::CodeW-1:0]  record_lane2_i,
  input  logic signed [sqd_pkg::CodeW-1:0]  record_lane3_i,
  input  logic [sqd_pkg::CodeW-1:0]       query_lane0_i,
  input  logic [sqd_pkg::CodeW-1:0]       query_lane1_i,
  input  logic [sqd_pkg::CodeW-1:0]       query_lane2_i,
  input  logic [sqd_pkg::CodeW-1:0]       query_lane3_i,
  input  logic [sqd_pkg::CountW-1:0]      lanes_valid_i,
  input  logic                            last_of_record_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [sqd_pkg::DistW-1:0]       distance_o,
  output logic                            saturated_o
);
  import sqd_pkg::*;

  logic [CodeW-1:0] rec   [Lanes];
  logic [CodeW-1:0] qry   [Lanes];
  logic             mid_push, mid_full, mid_pop, mid_empty;
  sqd_item_t        mid_in, mid_out;
  logic             out_push, out_full;
  sqd_result_t      out_in, out_head;

  assign rec[0] = record_lane0_i;
  assign rec[1] = record_lane1_i;
  assign rec[2] = record_lane2_i;
  assign rec[3] = record_lane3_i;
  assign qry[0] = query_lane0_i;
  assign qry[1] = query_lane1_i;
  assign qry[2] = query_lane2_i;
  assign qry[3] = query_lane3_i;

  sqd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rec_i         (rec),
    .qry_i         (qry),
    .lanes_valid_i (lanes_valid_i),
    .last_i        (last_of_record_i),
    .mid_push_o    (mid_push),
    .mid_item_o    (mid_in),
    .mid_full_i    (mid_full)
  );

  sqd_fifo #(
    .Width ($bits(sqd_item_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  sqd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mid_empty_i  (mid_empty),
    .mid_item_i   (mid_out),
    .mid_pop_o    (mid_pop),
    .out_full_i   (out_full),
    .out_push_o   (out_push),
    .out_result_o (out_in)
  );

  sqd_fifo #(
    .Width ($bits(sqd_result_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_head),
    .empty_o (empty)
  );

  assign distance_o  = out_head.distance;
  assign saturated_o = out_head.saturated;

endmodule

>>> design/sqd_fifo.sv
// Small first-in first-out queue with push/full and pop/empty sides.
// Depends on nothing; used between the front and back parts and at the output.
module sqd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/sqd_front.sv
// Front part: accepts items, masks idle lanes, squares each lane difference
// and sums the lanes into one queue entry. Depends on sqd_pkg.
module sqd_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [sqd_pkg::CodeW-1:0]              rec_i [sqd_pkg::Lanes],
  input  logic [sqd_pkg::CodeW-1:0]              qry_i [sqd_pkg::Lanes],
  input  logic [sqd_pkg::CountW-1:0]             lanes_valid_i,
  input  logic                                   last_i,
  output logic                                   mid_push_o,
  output sqd_pkg::sqd_item_t                     mid_item_o,
  input  logic                                   mid_full_i
);
  import sqd_pkg::*;

  logic [CountW-1:0]   count;
  logic [SqW-1:0]      sq_d [Lanes];
  logic [SqW-1:0]      sq_q [Lanes];
  logic                s1_last_q, s1_valid_q;
  logic [LaneSumW-1:0] lane_sum;
  sqd_item_t           s2_item_q;
  logic                s2_valid_q;
  logic                s1_ready, s2_ready, accept;

  assign s2_ready = !s2_valid_q || !mid_full_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign accept   = push && s1_ready;
  assign full     = !s1_ready;

  assign count = (lanes_valid_i > CountW'(Lanes)) ? CountW'(Lanes) : lanes_valid_i;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      sq_d[i] = (CountW'(i) < count) ? lane_square(rec_i[i], qry_i[i]) : '0;
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < Lanes; i++) begin
      lane_sum = lane_sum + LaneSumW'(sq_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sq_q      <= sq_d;
      s1_last_q <= last_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_item_q.lane_sum <= lane_sum;
      s2_item_q.last     <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= push;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  assign mid_push_o = s2_valid_q && !mid_full_i;
  assign mid_item_o = s2_item_q;

endmodule

>>> design/sqd_back.sv
// Back part: accumulates lane sums with saturation and hands a result to
// the output queue at the end of each record. Depends on sqd_pkg.
module sqd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 mid_empty_i,
  input  sqd_pkg::sqd_item_t   mid_item_i,
  output logic                 mid_pop_o,
  input  logic                 out_full_i,
  output logic                 out_push_o,
  output sqd_pkg::sqd_result_t out_result_o
);
  import sqd_pkg::*;

  logic [DistW-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d;
  logic [DistW:0]   total;
  logic             carry;
  logic [DistW-1:0] next_sum;

  assign mid_pop_o  = !mid_empty_i && (!mid_item_i.last || !out_full_i);
  assign out_push_o = mid_pop_o && mid_item_i.last;

  assign total    = {1'b0, sum_q} + (DistW + 1)'(mid_item_i.lane_sum);
  assign carry    = total[DistW];
  assign next_sum = carry ? '1 : total[DistW-1:0];

  assign out_result_o.distance  = next_sum;
  assign out_result_o.saturated = ovf_q || carry;

  always_comb begin
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (mid_pop_o) begin
      if (mid_item_i.last) begin
        sum_d = '0;
        ovf_d = 1'b0;
      end else begin
        sum_d = next_sum;
        ovf_d = ovf_q || carry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

>>> design/sqd_checker.sv
// Port-level checks on the squared L2 distance block, attached by bind.
// Depends on sqd_pkg and the top level query_sq_l2_uint8_distance.
module sqd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      full,
  input logic                      empty,
  input logic                      pop,
  input logic [sqd_pkg::DistW-1:0] distance_o,
  input logic                      saturated_o
);
  import sqd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("Block not empty and ready after a reset cycle.");

  a_sat_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |-> (distance_o == {DistW{1'b1}}))
    else $error("Saturated result without an all-ones distance.");

  a_full_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("Input side stalled while no result is waiting.");

  a_head_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(distance_o) && $stable(saturated_o)))
    else $error("Waiting result changed before it was taken.");

endmodule

bind query_sq_l2_uint8_distance sqd_checker u_sqd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .distance_o  (distance_o),
  .saturated_o (saturated_o)
);

>>> sim/query_sq_l2_uint8_distance_tb.sv
// Self-checking testbench for query_sq_l2_uint8_distance: a clocked driver and
// monitor with an independent predictor of the squared L2 sum and its saturation.
// Depends on sqd_pkg and the query_sq_l2_uint8_distance top level.
module query_sq_l2_uint8_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned RandomItems = 900;
  localparam int unsigned QuietFrom   = 300;
  localparam int unsigned QuietTo     = 700;

  typedef logic [Lanes-1:0][CodeW-1:0] lane_codes_t;

  typedef struct {
    lane_codes_t       rec;
    lane_codes_t       qry;
    logic [CountW-1:0] count;
    logic              closing;
    bit                drain;
  } stim_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic signed [CodeW-1:0] record_lane0 = '0;
  logic signed [CodeW-1:0] record_lane1 = '0;
  logic signed [CodeW-1:0] record_lane2 = '0;
  logic signed [CodeW-1:0] record_lane3 = '0;
  logic [CodeW-1:0] query_lane0 = '0;
  logic [CodeW-1:0] query_lane1 = '0;
  logic [CodeW-1:0] query_lane2 = '0;
  logic [CodeW-1:0] query_lane3 = '0;
  logic [CountW-1:0] lanes_valid = '0;
  logic last_of_record = 1'b0;
  logic [DistW-1:0] distance_o;
  logic saturated_o;

  stim_item_t pending_items[$];
  sqd_pkg::sqd_result_t distance_q[$];
  sqd_pkg::sqd_result_t want_res;

  logic [DistW-1:0] acc_sum = '0;
  logic acc_sat = 1'b0;
  int unsigned closes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;

  query_sq_l2_uint8_distance uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .record_lane0_i   (record_lane0),
    .record_lane1_i   (record_lane1),
    .record_lane2_i   (record_lane2),
    .record_lane3_i   (record_lane3),
    .query_lane0_i    (query_lane0),
    .query_lane1_i    (query_lane1),
    .query_lane2_i    (query_lane2),
    .query_lane3_i    (query_lane3),
    .lanes_valid_i    (lanes_valid),
    .last_of_record_i (last_of_record),
    .empty            (empty),
    .pop              (pop),
    .distance_o       (distance_o),
    .saturated_o      (saturated_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit take_break();
    return !(cycle_cnt >= QuietFrom && cycle_cnt < QuietTo) && ($urandom_range(99) < 13);
  endfunction

  task automatic add_item(input lane_codes_t rec, input lane_codes_t qry,
                          input logic [CountW-1:0] count, input logic closing,
                          input bit drain);
    stim_item_t it;
    it.rec = rec;
    it.qry = qry;
    it.count = count;
    it.closing = closing;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  task automatic accumulate_item(input stim_item_t it);
    int unsigned n;
    longint unsigned total;
    int raw;
    int diff;
    sqd_pkg::sqd_result_t res;
    n = (it.count > Lanes) ? Lanes : it.count;
    total = acc_sum;
    for (int i = 0; i < n; i++) begin
      raw = int'(it.rec[i] ^ QueryOffset);
      diff = raw - int'(it.qry[i]);
      total += longint'(diff * diff);
    end
    if (total > longint'({DistW{1'b1}})) begin
      acc_sum = '1;
      acc_sat = 1'b1;
    end else begin
      acc_sum = total[DistW-1:0];
    end
    if (it.closing) begin
      res.distance = acc_sum;
      res.saturated = acc_sat;
      distance_q.push_back(res);
      closes_sent++;
      acc_sum = '0;
      acc_sat = 1'b0;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("query_sq_l2_uint8_distance verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        accumulate_item(pending_items[0]);
        void'(pending_items.pop_front());
      end
      if (!(push && full)) begin
        if (pending_items.size() != 0 && !take_break() &&
            !(pending_items[0].drain && results_seen != closes_sent)) begin
          push <= 1'b1;
          record_lane0 <= pending_items[0].rec[0];
          record_lane1 <= pending_items[0].rec[1];
          record_lane2 <= pending_items[0].rec[2];
          record_lane3 <= pending_items[0].rec[3];
          query_lane0 <= pending_items[0].qry[0];
          query_lane1 <= pending_items[0].qry[1];
          query_lane2 <= pending_items[0].qry[2];
          query_lane3 <= pending_items[0].qry[3];
          lanes_valid <= pending_items[0].count;
          last_of_record <= pending_items[0].closing;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        results_seen <= results_seen + 1;
        if (distance_q.size() == 0) begin
          $error("unexpected item: distance %0d saturated %0d", distance_o, saturated_o);
          errors++;
        end else begin
          want_res = distance_q.pop_front();
          if (distance_o !== want_res.distance) begin
            $error("distance mismatch: expected %0d, actual %0d",
                   want_res.distance, distance_o);
            errors++;
          end
          if (saturated_o !== want_res.saturated) begin
            $error("saturated mismatch: expected %0d, actual %0d",
                   want_res.saturated, saturated_o);
            errors++;
          end
        end
      end
      pop <= !take_break();
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    bit noisy;
    lane_codes_t rec;
    lane_codes_t qry;
    logic [CountW-1:0] count;

    add_item({Lanes{8'h7F}}, {Lanes{8'h00}}, CountW'(Lanes), 1'b1, 1'b0);
    add_item({Lanes{8'h80}}, {Lanes{8'hFF}}, CountW'(Lanes), 1'b1, 1'b0);
    add_item({Lanes{8'h00}}, {Lanes{8'h80}}, CountW'(Lanes), 1'b1, 1'b0);
    add_item({Lanes{8'hFF}}, {Lanes{8'hFF}}, CountW'(Lanes), 1'b1, 1'b0);
    add_item({Lanes{8'hFF}}, {Lanes{8'h00}}, CountW'(0), 1'b1, 1'b0);
    for (int c = 5; c <= 7; c++) begin
      add_item($urandom, $urandom, CountW'(c), 1'b1, 1'b0);
    end
    for (int c = 1; c <= 3; c++) begin
      add_item($urandom, $urandom, CountW'(c), 1'b0, 1'b0);
    end
    add_item($urandom, $urandom, CountW'(0), 1'b1, 1'b0);
    add_item({Lanes{8'h7F}}, {Lanes{8'h00}}, CountW'(0), 1'b0, 1'b0);
    add_item({Lanes{8'h7F}}, {Lanes{8'h00}}, CountW'(0), 1'b1, 1'b0);
    add_item({8'hFE, 8'h01, 8'h80, 8'h7F}, {8'hAA, 8'h55, 8'hFF, 8'h00},
             CountW'(Lanes), 1'b1, 1'b0);
    add_item($urandom, $urandom, CountW'(Lanes), 1'b1, 1'b1);
    add_item({8'h01, 8'h80, 8'h7F, 8'h00}, {8'hFF, 8'h01, 8'h00, 8'h80},
             CountW'(2), 1'b1, 1'b0);

    n = 0;
    while (n < RandomItems) begin
      len = $urandom_range(1, 6);
      noisy = ($urandom_range(99) < 15);
      for (int j = 0; j < len; j++) begin
        rec = $urandom;
        qry = $urandom;
        count = ($urandom_range(99) < 60) ? CountW'(Lanes) : CountW'($urandom_range(7));
        add_item(rec, qry, count, noisy ? 1'($urandom_range(1)) : (j == len - 1),
                 (j == 0) && ($urandom_range(99) < 2));
        n++;
      end
    end
    add_item($urandom, $urandom, CountW'(Lanes), 1'b1, 1'b1);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0) @(posedge clk_i);
    while (distance_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0 && distance_q.size() == 0) begin
      $display("query_sq_l2_uint8_distance verification clean");
    end else begin
      $display("query_sq_l2_uint8_distance verification failed");
    end
    $finish;
  end

endmodule
